// ===== rtl/core/cdad_pkg.sv =====
// ----------------------------------------------------------------------------
// cdad_pkg: shared types and constants of the date adder
// Widths, calendar constants, sequencer states and the structs that pass
// between the sequencer, the month length unit and the shared adder.
// ----------------------------------------------------------------------------
package cdad_pkg;

  // Internal widths: the year may run past the 14-bit input range while
  // stepping, and the running day count reaches about 33k.
  localparam int unsigned YearW  = 15;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned RemW   = 16;
  localparam int unsigned LenW   = 9;

  localparam logic [MonthW-1:0] MonthJan      = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb      = 4'd2;
  localparam logic [MonthW-1:0] MonthsPerYear = 4'd12;
  localparam logic [YearW-1:0]  YearLimit     = 15'd10099;

  localparam logic [LenW-1:0] DaysCommonYear = 9'd365;
  localparam logic [LenW-1:0] DaysLeapYear   = 9'd366;
  localparam logic [DayW-1:0] DaysLeapFeb    = 5'd29;

  // Divisibility by 25 through the multiplicative inverse of 25 modulo 2^16.
  localparam logic [15:0] Inv25    = 16'd23593;
  localparam logic [15:0] Div25Max = 16'd2621;

  typedef enum logic [2:0] {
    StIdle,
    StAccum,
    StYears,
    StMonths,
    StFinish
  } state_e;

  typedef enum logic {
    AluAdd,
    AluSub
  } alu_op_e;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic              whole_year;
  } len_req_t;

  typedef struct packed {
    logic [RemW-1:0] res;
    logic            gt;
  } alu_res_t;

  // Length of a month in a common year.
  function automatic logic [DayW-1:0] month_len_base(input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    unique case (m)
      4'd2:                      len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/core/cdad_len_unit.sv =====
// ----------------------------------------------------------------------------
// cdad_len_unit: month and year length
// Applies the full Gregorian leap rule to the current year and returns either
// the length of the requested month or the length of the whole year.
// ----------------------------------------------------------------------------
module cdad_len_unit (
  input  cdad_pkg::len_req_t           req_i,
  output logic [cdad_pkg::LenW-1:0]    len_o
);

  logic [15:0] prod;
  logic        div4;
  logic        div16;
  logic        div25;
  logic        leap;

  // The low half of y * inverse(25) stays small exactly for multiples of 25.
  assign prod  = 16'({1'b0, req_i.year} * cdad_pkg::Inv25);
  assign div25 = (prod <= cdad_pkg::Div25Max);
  assign div4  = (req_i.year[1:0] == 2'd0);
  assign div16 = (req_i.year[3:0] == 4'd0);
  assign leap  = div4 && (!div25 || div16);

  always_comb begin
    if (req_i.whole_year) begin
      len_o = leap ? cdad_pkg::DaysLeapYear : cdad_pkg::DaysCommonYear;
    end else if (req_i.month == cdad_pkg::MonthFeb && leap) begin
      len_o = {4'd0, cdad_pkg::DaysLeapFeb};
    end else begin
      len_o = {4'd0, cdad_pkg::month_len_base(req_i.month)};
    end
  end

endmodule

// ===== rtl/core/cdad_alu.sv =====
// ----------------------------------------------------------------------------
// cdad_alu: shared adder and comparator
// Adds a length to the running day count, or subtracts it and reports
// whether the count was strictly greater than the length.
// ----------------------------------------------------------------------------
module cdad_alu (
  input  cdad_pkg::alu_op_e            op_i,
  input  logic [cdad_pkg::RemW-1:0]    a_i,
  input  logic [cdad_pkg::LenW-1:0]    b_i,
  output cdad_pkg::alu_res_t           res_o
);

  logic [cdad_pkg::RemW:0] diff;

  assign diff = {1'b0, a_i} - {(cdad_pkg::RemW - cdad_pkg::LenW + 1)'(0), b_i};

  always_comb begin
    res_o.gt = !diff[cdad_pkg::RemW] && (diff[cdad_pkg::RemW-1:0] != '0);
    unique case (op_i)
      cdad_pkg::AluAdd:
        res_o.res = a_i + {(cdad_pkg::RemW - cdad_pkg::LenW)'(0), b_i};
      cdad_pkg::AluSub:
        res_o.res = diff[cdad_pkg::RemW-1:0];
      default:
        res_o.res = a_i;
    endcase
  end

endmodule

// ===== rtl/core/calendar_date_add_days_unit.sv =====
// Sequence from the input transfer to out_valid_o: sum the months before the
// start month (clamped), skip whole years, step the months of the final year,
// then load the output register. One month or one year per cycle through
// the shared adder. One item at a time: the input stalls until the
// result enters the output register and is free again the cycle after.
// Reset (asynchronous, active low) empties the block.
// ----------------------------------------------------------------------------
// calendar_date_add_days_unit: Gregorian date plus a day count
// A small sequencer drives one shared add/compare unit: it accumulates the
// day of the year, skips whole years, then steps month by month.
// ----------------------------------------------------------------------------
module calendar_date_add_days_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [13:0] start_year_i,
  input  logic [3:0]  start_month_i,
  input  logic [4:0]  start_day_i,
  input  logic [14:0] days_to_add_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [13:0] result_year_o,
  output logic [3:0]  result_month_o,
  output logic [4:0]  result_day_o,
  output logic        year_overflow_o
);

  cdad_pkg::state_e state_q, state_d;

  logic [cdad_pkg::YearW-1:0]  year_q, year_d;
  logic [cdad_pkg::MonthW-1:0] tgt_q, tgt_d;
  logic [cdad_pkg::MonthW-1:0] m_q, m_d;
  logic [cdad_pkg::RemW-1:0]   rem_q, rem_d;

  logic        out_valid_q, out_valid_d;
  logic [13:0] res_year_q, res_year_d;
  logic [3:0]  res_month_q, res_month_d;
  logic [4:0]  res_day_q, res_day_d;
  logic        res_ovf_q, res_ovf_d;

  logic                      in_xfer;
  logic                      out_free;
  logic                      accum_more;
  logic [cdad_pkg::LenW-1:0] len;
  cdad_pkg::len_req_t        len_req;
  cdad_pkg::alu_op_e         alu_op;
  cdad_pkg::alu_res_t        alu_res;
  logic [cdad_pkg::MonthW-1:0] month_clamped;
  logic [cdad_pkg::DayW-1:0]   day_clamped;

  assign in_stall_o = (state_q != cdad_pkg::StIdle);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign accum_more = (m_q < tgt_q);

  assign len_req.year       = year_q;
  assign len_req.month      = m_q;
  assign len_req.whole_year = (state_q == cdad_pkg::StYears);
  assign alu_op = (state_q == cdad_pkg::StAccum) ? cdad_pkg::AluAdd : cdad_pkg::AluSub;

  cdad_len_unit u_len (
    .req_i (len_req),
    .len_o (len)
  );

  cdad_alu u_alu (
    .op_i  (alu_op),
    .a_i   (rem_q),
    .b_i   (len),
    .res_o (alu_res)
  );

  always_comb begin
    if (start_month_i == 4'd0) begin
      month_clamped = cdad_pkg::MonthJan;
    end else if (start_month_i > cdad_pkg::MonthsPerYear) begin
      month_clamped = cdad_pkg::MonthsPerYear;
    end else begin
      month_clamped = start_month_i;
    end
    day_clamped = (start_day_i == 5'd0) ? 5'd1 : start_day_i;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cdad_pkg::StIdle:   if (in_xfer) state_d = cdad_pkg::StAccum;
      cdad_pkg::StAccum:  if (!accum_more) state_d = cdad_pkg::StYears;
      cdad_pkg::StYears:  if (!alu_res.gt) state_d = cdad_pkg::StMonths;
      cdad_pkg::StMonths: if (!alu_res.gt) state_d = cdad_pkg::StFinish;
      cdad_pkg::StFinish: if (out_free) state_d = cdad_pkg::StIdle;
      default:            state_d = cdad_pkg::StIdle;
    endcase
  end

  // Datapath updates per state.
  always_comb begin
    year_d      = year_q;
    tgt_d       = tgt_q;
    m_d         = m_q;
    rem_d       = rem_q;
    res_year_d  = res_year_q;
    res_month_d = res_month_q;
    res_day_d   = res_day_q;
    res_ovf_d   = res_ovf_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      cdad_pkg::StIdle: begin
        if (in_xfer) begin
          year_d = {1'b0, start_year_i};
          tgt_d  = month_clamped;
          m_d    = cdad_pkg::MonthJan;
          rem_d  = {11'd0, day_clamped} + {1'b0, days_to_add_i};
        end
      end
      cdad_pkg::StAccum: begin
        if (accum_more) begin
          rem_d = alu_res.res;
          m_d   = m_q + 4'd1;
        end else begin
          m_d = cdad_pkg::MonthJan;
        end
      end
      cdad_pkg::StYears: begin
        // Taking off a whole year is the same as stepping all twelve months.
        if (alu_res.gt) begin
          rem_d  = alu_res.res;
          year_d = year_q + 15'd1;
        end
      end
      cdad_pkg::StMonths: begin
        if (alu_res.gt) begin
          rem_d = alu_res.res;
          m_d   = m_q + 4'd1;
        end
      end
      cdad_pkg::StFinish: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          res_month_d = m_q;
          res_day_d   = rem_q[cdad_pkg::DayW-1:0];
          if (year_q > cdad_pkg::YearLimit) begin
            res_year_d = cdad_pkg::YearLimit[13:0];
            res_ovf_d  = 1'b1;
          end else begin
            res_year_d = year_q[13:0];
            res_ovf_d  = 1'b0;
          end
        end
      end
      default: begin
        out_valid_d = out_valid_q && out_stall_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cdad_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    year_q      <= year_d;
    tgt_q       <= tgt_d;
    m_q         <= m_d;
    rem_q       <= rem_d;
    res_year_q  <= res_year_d;
    res_month_q <= res_month_d;
    res_day_q   <= res_day_d;
    res_ovf_q   <= res_ovf_d;
  end

  assign out_valid_o     = out_valid_q;
  assign result_year_o   = res_year_q;
  assign result_month_o  = res_month_q;
  assign result_day_o    = res_day_q;
  assign year_overflow_o = res_ovf_q;

endmodule

// ===== tb/date_add_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_add_checker: prediction and comparison for the date adder
// Watches both channels of the block. Every input transfer queues the date it
// should produce; every output transfer is compared with the oldest one.
// ----------------------------------------------------------------------------
module date_add_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [13:0] start_year_i,
  input  logic [3:0]  start_month_i,
  input  logic [4:0]  start_day_i,
  input  logic [14:0] days_to_add_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [13:0] result_year_i,
  input  logic [3:0]  result_month_i,
  input  logic [4:0]  result_day_i,
  input  logic        year_overflow_i,
  output int unsigned error_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        overflow;
  } date_t;

  date_t       due_dates[$];
  int unsigned errors_seen = 0;

  function automatic bit is_leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
    int unsigned len;
    case (m)
      cdad_pkg::MonthFeb: len = is_leap_year(y) ? 29 : 28;
      4, 6, 9, 11:        len = 30;
      default:            len = 31;
    endcase
    return len;
  endfunction

  // Day of the year plus the count, then walk forward a month at a time
  // from January of the start year.
  function automatic date_t advance_date(input logic [13:0] y_in, input logic [3:0] m_in,
                                         input logic [4:0] d_in, input logic [14:0] count);
    int unsigned year;
    int unsigned month;
    int unsigned day;
    int unsigned remain;
    int unsigned m;
    date_t       res;
    year   = y_in;
    month  = m_in;
    day    = d_in;
    remain = 0;
    if (month < cdad_pkg::MonthJan) month = cdad_pkg::MonthJan;
    if (month > cdad_pkg::MonthsPerYear) month = cdad_pkg::MonthsPerYear;
    if (day == 0) day = 1;
    for (m = cdad_pkg::MonthJan; m < month; m++) remain += month_days(year, m);
    remain += day + count;
    m = cdad_pkg::MonthJan;
    while (remain > month_days(year, m)) begin
      remain -= month_days(year, m);
      m++;
      if (m > cdad_pkg::MonthsPerYear) begin
        m = cdad_pkg::MonthJan;
        year++;
      end
    end
    res.overflow = (year > cdad_pkg::YearLimit);
    if (res.overflow) year = cdad_pkg::YearLimit;
    res.year  = 14'(year);
    res.month = 4'(m);
    res.day   = 5'(remain);
    return res;
  endfunction

  always @(posedge clk_i) begin
    date_t got;
    date_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        got = '{result_year_i, result_month_i, result_day_i, year_overflow_i};
        if (due_dates.size() == 0) begin
          errors_seen++;
          if (errors_seen <= 10)
            $display("%0t: unexpected result %0d-%0d-%0d ovf %0b", $realtime,
                     got.year, got.month, got.day, got.overflow);
        end else begin
          want = due_dates.pop_front();
          if (got.year !== want.year || got.month !== want.month ||
              got.day !== want.day || got.overflow !== want.overflow) begin
            errors_seen++;
            if (errors_seen <= 10)
              $display("%0t: mismatch: expected %0d-%0d-%0d ovf %0b, got %0d-%0d-%0d ovf %0b",
                       $realtime, want.year, want.month, want.day, want.overflow,
                       got.year, got.month, got.day, got.overflow);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        due_dates.push_back(advance_date(start_year_i, start_month_i, start_day_i,
                                         days_to_add_i));
    end
    error_count_o <= errors_seen;
    pending_o     <= due_dates.size();
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the Gregorian date adder
// Sends directed corner dates and then random dates under random idling on
// both channels; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [13:0] start_year_i   = '0;
  logic [3:0]  start_month_i  = '0;
  logic [4:0]  start_day_i    = '0;
  logic [14:0] days_to_add_i  = '0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [13:0] result_year_o;
  logic [3:0]  result_month_o;
  logic [4:0]  result_day_o;
  logic        year_overflow_o;

  int unsigned error_count;
  int unsigned pending_count;
  bit          calm_phase = 1'b0;
  int          stall_left = 0;

  calendar_date_add_days_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .start_year_i   (start_year_i),
    .start_month_i  (start_month_i),
    .start_day_i    (start_day_i),
    .days_to_add_i  (days_to_add_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_year_o  (result_year_o),
    .result_month_o (result_month_o),
    .result_day_o   (result_day_o),
    .year_overflow_o(year_overflow_o)
  );

  date_add_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .start_year_i   (start_year_i),
    .start_month_i  (start_month_i),
    .start_day_i    (start_day_i),
    .days_to_add_i  (days_to_add_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_year_i  (result_year_o),
    .result_month_i (result_month_o),
    .result_day_i   (result_day_o),
    .year_overflow_i(year_overflow_o),
    .error_count_o  (error_count),
    .pending_o      (pending_count)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Receiver back-pressure in short random bursts, switched off near the end.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (rst_ni && !calm_phase && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 5) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Called at a rising edge; returns at the edge of the transfer, or after
  // an idle burst that follows it.
  task automatic send_date(input logic [13:0] y, input logic [3:0] m,
                           input logic [4:0] d, input logic [14:0] n);
    bit taken;
    in_valid_i    <= 1'b1;
    start_year_i  <= y;
    start_month_i <= m;
    start_day_i   <= d;
    days_to_add_i <= n;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    if (!calm_phase && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_count != 0);
    @(posedge clk_i);
  endtask

  task automatic send_random_dates(input int unsigned count);
    logic [13:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    logic [14:0] n;
    int unsigned pick;
    repeat (count) begin
      y = 14'($urandom_range(1, 9999));
      m = 4'($urandom_range(1, 12));
      d = 5'($urandom_range(1, 28));
      case ($urandom_range(0, 9))
        0: y = 14'($urandom_range(9900, 10099));
        1: y = 14'($urandom);
        2: begin
          m = 4'($urandom);
          d = 5'($urandom);
        end
        3: begin
          // Around the end of February in years where the leap rule bites.
          m = 4'd2;
          d = 5'($urandom_range(27, 29));
          y = $urandom_range(0, 1) ? 14'(100 * $urandom_range(0, 99))
                                   : 14'(4 * $urandom_range(0, 2499));
        end
        4: d = 5'($urandom_range(29, 31));
        default: ;
      endcase
      pick = $urandom_range(0, 3);
      if (pick < 2) n = 15'($urandom_range(0, 400));
      else if (pick == 2) n = 15'($urandom_range(0, 3000));
      else n = 15'($urandom);
      send_date(y, m, d, n);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_date(14'd1, 4'd1, 5'd1, 15'd0);
    send_date(14'd9999, 4'd12, 5'd31, 15'd32767);
    send_date(14'd16383, 4'd15, 5'd31, 15'd32767);
    send_date(14'd0, 4'd0, 5'd0, 15'd0);
    send_date(14'd2000, 4'd2, 5'd28, 15'd1);
    send_date(14'd1900, 4'd2, 5'd28, 15'd1);
    send_date(14'd2024, 4'd2, 5'd29, 15'd365);
    send_date(14'd2023, 4'd12, 5'd31, 15'd1);
    send_date(14'd2023, 4'd1, 5'd31, 15'd0);
    send_date(14'd2023, 4'd4, 5'd31, 15'd0);
    send_date(14'd2023, 4'd2, 5'd31, 15'd0);
    send_date(14'd10099, 4'd12, 5'd31, 15'd0);
    send_date(14'd10099, 4'd12, 5'd31, 15'd1);
    send_date(14'd2021, 4'd13, 5'd5, 15'd10);
    send_date(14'd2021, 4'd6, 5'd0, 15'd0);
    send_date(14'd0, 4'd2, 5'd28, 15'd1);
    send_date(14'd1, 4'd1, 5'd1, 15'd32767);
    send_date(14'd8191, 4'd7, 5'd15, 15'd16384);
    send_date(14'd10010, 4'd1, 5'd1, 15'd32767);
    send_date(14'd2400, 4'd3, 5'd1, 15'd0);

    send_random_dates(200);
    // Let the block drain completely once before carrying on.
    wait_for_results();
    send_random_dates(220);
    calm_phase = 1'b1;
    send_random_dates(80);

    wait_for_results();
    repeat (150) @(posedge clk_i);
    if (error_count == 0 && pending_count == 0) begin
      $display("calendar_date_add_days_unit test passed");
    end else begin
      $display("calendar_date_add_days_unit test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("calendar_date_add_days_unit test failed");
    $finish;
  end

endmodule
